FILE: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ULFR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ULFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/ulfr_pkg.sv
package ulfr_pkg;

	localparam int PACKET_BYTES = 8;
	localparam int STORE_DEPTH  = PACKET_BYTES + 1;
	localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
	localparam int BYTE_CNT_W   = $clog2(STORE_DEPTH + 1);

	// Input item kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_WAIT = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd0;
	localparam logic [1:0] CFG_START_BYTE  = 2'd1;
	localparam logic [1:0] CFG_STUFF_MASK  = 2'd2;

	localparam logic [7:0] ESCAPE_RESET = 8'd125;
	localparam logic [7:0] START_RESET  = 8'd126;
	localparam logic [7:0] MASK_RESET   = 8'd32;

	// Frame layout
	localparam int IDX_ID_A  = 1;
	localparam int IDX_ID_B  = 2;
	localparam int IDX_PRIM  = 3;
	localparam int IDX_ADDR0 = 4;
	localparam int IDX_ADDR1 = 5;
	localparam int IDX_ADDR2 = 6;
	localparam int IDX_ADDR3 = 7;

	localparam logic [7:0] ID_WORD_A     = 8'h5E;
	localparam logic [7:0] ID_WORD_B     = 8'h50;
	localparam logic [7:0] PRIM_PWR_ACK  = 8'h80;
	localparam logic [7:0] PRIM_VER_ACK  = 8'h81;
	localparam logic [7:0] PRIM_ADDR_REQ = 8'h82;
	localparam logic [7:0] PRIM_END      = 8'h83;
	localparam logic [7:0] PRIM_CRC_ERR  = 8'h84;

	// Protocol states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_PWR_REQ  = 4'd1;
	localparam logic [3:0] ST_PWR_ACK  = 4'd2;
	localparam logic [3:0] ST_VER_REQ  = 4'd3;
	localparam logic [3:0] ST_VER_ACK  = 4'd4;
	localparam logic [3:0] ST_XFER     = 4'd5;
	localparam logic [3:0] ST_DATA_REQ = 4'd6;
	localparam logic [3:0] ST_COMPLETE = 4'd7;
	localparam logic [3:0] ST_FAIL     = 4'd8;

	localparam logic OUTCOME_FRAME   = 1'b0;
	localparam logic OUTCOME_TIMEOUT = 1'b1;

	typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

	typedef struct packed {
		logic [3:0]  state;
		logic        load_addr;
		logic [31:0] addr;
	} decode_t;

endpackage

FILE: src/ulfr_in_if.sv
interface ulfr_in_if;
	import ulfr_pkg::*;

	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  rx_byte;
	logic [11:0] wait_timeout;
	logic [3:0]  expected_state;
	logic        force_state;
	logic [3:0]  new_state;

	modport source (
		output valid, kind, rx_byte, wait_timeout, expected_state, force_state, new_state,
		input  ready
	);
	modport sink (
		input  valid, kind, rx_byte, wait_timeout, expected_state, force_state, new_state,
		output ready
	);
endinterface

FILE: src/ulfr_out_if.sv
interface ulfr_out_if;
	import ulfr_pkg::*;

	logic        valid;
	logic        ready;
	logic        outcome;
	logic [3:0]  link_state;
	logic [31:0] requested_address;
	logic        reached;

	modport source (
		output valid, outcome, link_state, requested_address, reached,
		input  ready
	);
	modport sink (
		input  valid, outcome, link_state, requested_address, reached,
		output ready
	);
endinterface

FILE: src/ulfr_decode.sv
module ulfr_decode
	import ulfr_pkg::*;
(
	input  frame_t     frame,
	input  logic [3:0] cur_state,
	output decode_t    dec
);

	logic id_ok;

	assign id_ok = (frame[IDX_ID_A] == ID_WORD_A) && (frame[IDX_ID_B] == ID_WORD_B);

	always_comb begin
		dec.state     = cur_state;
		dec.load_addr = 1'b0;
		dec.addr      = {frame[IDX_ADDR3], frame[IDX_ADDR2], frame[IDX_ADDR1], frame[IDX_ADDR0]};
		if (id_ok) begin
			unique case (frame[IDX_PRIM])
				PRIM_PWR_ACK: begin
					if (cur_state == ST_PWR_REQ) dec.state = ST_PWR_ACK;
				end
				PRIM_VER_ACK: begin
					if (cur_state == ST_VER_REQ) dec.state = ST_VER_ACK;
				end
				PRIM_ADDR_REQ: begin
					if (cur_state == ST_XFER) begin
						dec.state     = ST_DATA_REQ;
						dec.load_addr = 1'b1;
					end
				end
				PRIM_END:     dec.state = ST_COMPLETE;
				PRIM_CRC_ERR: dec.state = ST_FAIL;
				default: ;
			endcase
		end
	end

endmodule

FILE: src/update_link_frame_receiver.sv
// Channel  | Role   | Payload
// item     | sink   | kind, rx_byte, wait_timeout, expected_state, force_state, new_state
// result   | source | outcome, link_state, requested_address, reached
// cfg      | write  | cfg_wr_en, cfg_idx, cfg_wdata (escape, start, stuff mask)
//
// One item per cycle while the result register is not stalled: accepted into the input
// register, then processed by the destuff, count and decode logic; any result lands
// in the result register.
// Reset clears all control state and loads the default configuration bytes.
// A stalled result register holds the processing stage; the input register still
// takes one more transaction while it is empty.
module update_link_frame_receiver
	import ulfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ulfr_in_if.sink    item,
	ulfr_out_if.source result,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_wdata
);

`include "assert_macros.svh"

	// Configuration registers
	logic [7:0] escape_byte_q, start_byte_q, stuff_mask_q;

	// Input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  rx_byte_s1;
	logic [11:0] wait_timeout_s1;
	logic [3:0]  expected_state_s1;
	logic        force_state_s1;
	logic [3:0]  new_state_s1;

	// Receiver state
	frame_t                frame_store_q;
	logic [BYTE_CNT_W-1:0] byte_count_q, byte_count_d;
	logic                  escape_pending_q, escape_pending_d;
	logic [11:0]           idle_ticks_q, idle_ticks_d;
	logic                  wait_active_q, wait_active_d;
	logic [3:0]            hoped_state_q, hoped_state_d;
	logic [11:0]           timeout_limit_q, timeout_limit_d;
	logic [3:0]            protocol_state_q, protocol_state_d;
	logic [31:0]           address_reg_q, address_reg_d;

	// Result register
	logic        res_valid_s2;
	logic        res_outcome_s2;
	logic [3:0]  res_state_s2;
	logic [31:0] res_addr_s2;
	logic        res_reached_s2;

	logic                  advance, go;
	logic                  emit, emit_outcome, emit_reached;
	logic                  store_wr;
	logic [7:0]            store_val;
	logic [BYTE_CNT_W-1:0] count_inc;
	decode_t               dec;

	// Processing stage moves whenever the result register is free or being drained
	assign advance    = !res_valid_s2 || result.ready;
	assign go         = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	ulfr_decode u_decode (
		.frame     (frame_store_q),
		.cur_state (protocol_state_q),
		.dec       (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_byte_q <= ESCAPE_RESET;
			start_byte_q  <= START_RESET;
			stuff_mask_q  <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				CFG_ESCAPE_BYTE: escape_byte_q <= cfg_wdata;
				CFG_START_BYTE:  start_byte_q  <= cfg_wdata;
				CFG_STUFF_MASK:  stuff_mask_q  <= cfg_wdata;
				default: ;	// drop writes beyond the register list
			endcase
		end
	end

	// Input register: capture a transaction whenever the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1           <= item.kind;
			rx_byte_s1        <= item.rx_byte;
			wait_timeout_s1   <= item.wait_timeout;
			expected_state_s1 <= item.expected_state;
			force_state_s1    <= item.force_state;
			new_state_s1      <= item.new_state;
		end
	end

	assign count_inc = byte_count_q + BYTE_CNT_W'(1);

	// Per-item processing: wait setup, tick timeout, destuff and frame assembly
	always_comb begin
		byte_count_d     = byte_count_q;
		escape_pending_d = escape_pending_q;
		idle_ticks_d     = idle_ticks_q;
		wait_active_d    = wait_active_q;
		hoped_state_d    = hoped_state_q;
		timeout_limit_d  = timeout_limit_q;
		protocol_state_d = protocol_state_q;
		address_reg_d    = address_reg_q;
		emit             = 1'b0;
		emit_outcome     = OUTCOME_FRAME;
		emit_reached     = 1'b0;
		store_wr         = 1'b0;
		store_val        = escape_pending_q ? (rx_byte_s1 ^ stuff_mask_q) : rx_byte_s1;

		unique case (kind_s1)
			KIND_WAIT: begin
				// Open or restart the wait
				timeout_limit_d = wait_timeout_s1;
				hoped_state_d   = expected_state_s1;
				if (force_state_s1) protocol_state_d = new_state_s1;
				byte_count_d     = '0;
				escape_pending_d = 1'b0;
				idle_ticks_d     = '0;
				wait_active_d    = 1'b1;
			end
			KIND_TICK: begin
				if (wait_active_q) begin
					if (idle_ticks_q >= timeout_limit_q) begin
						wait_active_d = 1'b0;
						emit          = 1'b1;
						emit_outcome  = OUTCOME_TIMEOUT;
					end else begin
						idle_ticks_d = idle_ticks_q + 12'd1;
					end
				end
			end
			KIND_BYTE: begin
				if (wait_active_q) begin
					idle_ticks_d = '0;
					if (rx_byte_s1 == escape_byte_q) begin
						escape_pending_d = 1'b1;
					end else begin
						escape_pending_d = 1'b0;
						store_wr = (byte_count_q < BYTE_CNT_W'(STORE_DEPTH));
						// Start test uses the raw byte; once under way every byte counts
						if (byte_count_q != '0 || rx_byte_s1 == start_byte_q) begin
							byte_count_d = count_inc;
							if (count_inc >= BYTE_CNT_W'(STORE_DEPTH)) begin
								byte_count_d     = '0;
								wait_active_d    = 1'b0;
								protocol_state_d = dec.state;
								if (dec.load_addr) address_reg_d = dec.addr;
								emit         = 1'b1;
								emit_outcome = OUTCOME_FRAME;
								emit_reached = (dec.state == hoped_state_q);
							end
						end
					end
				end
			end
			default: ;	// unused kind: no effect
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			escape_pending_q <= 1'b0;
			idle_ticks_q     <= '0;
			wait_active_q    <= 1'b0;
			hoped_state_q    <= ST_IDLE;
			timeout_limit_q  <= '0;
			protocol_state_q <= ST_IDLE;
			address_reg_q    <= '0;
		end else if (go) begin
			byte_count_q     <= byte_count_d;
			escape_pending_q <= escape_pending_d;
			idle_ticks_q     <= idle_ticks_d;
			wait_active_q    <= wait_active_d;
			hoped_state_q    <= hoped_state_d;
			timeout_limit_q  <= timeout_limit_d;
			protocol_state_q <= protocol_state_d;
			address_reg_q    <= address_reg_d;
		end
	end

	// Frame bytes: written at the current count, no reset
	always_ff @(posedge clk) begin
		if (go && store_wr) begin
			frame_store_q[byte_count_q[STORE_IDX_W-1:0]] <= store_val;
		end
	end

	// Result register: load on a finished frame or timeout, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_outcome_s2 <= emit_outcome;
			res_state_s2   <= protocol_state_d;
			res_addr_s2    <= address_reg_d;
			res_reached_s2 <= emit_reached;
		end
	end

	assign result.valid             = res_valid_s2;
	assign result.outcome           = res_outcome_s2;
	assign result.link_state        = res_state_s2;
	assign result.requested_address = res_addr_s2;
	assign result.reached           = res_reached_s2;

	`ULFR_ASSERT(a_count_in_range, clk, arst_n, byte_count_q < BYTE_CNT_W'(STORE_DEPTH), "byte count past frame length")
	`ULFR_ASSERT(a_timeout_not_reached, clk, arst_n, (res_valid_s2 && res_outcome_s2) |-> !res_reached_s2, "timeout result flagged as reached")
	`ULFR_ASSERT(a_result_closes_wait, clk, arst_n, (go && emit) |=> !wait_active_q, "wait still open after a result")
	`ULFR_ASSERT(a_stall_cause, clk, arst_n, !item.ready |-> (valid_s1 && res_valid_s2 && !result.ready), "input stalled without a full pipeline")

endmodule

FILE: bench/update_link_frame_receiver_tb.sv
module update_link_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ulfr_pkg::*;

	// The item channel carries a two-bit kind; the fourth code has no meaning
	// and the block must drop it.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam int SEGMENTS     = 6;
	localparam int SEG_ITEMS    = 317;   // about 1900 items over the six segments
	localparam int HOLD_CYCLES  = 80;    // long receiver hold-off, enough to back up the pipe
	localparam int CFG_SETTLE   = 4;     // time to empty the input register, plus margin
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 1_000_000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rx_byte;
		logic [11:0] wait_timeout;
		logic [3:0]  expected_state;
		logic        force_state;
		logic [3:0]  new_state;
	} link_item_t;

	typedef struct packed {
		logic        outcome;
		logic [3:0]  link_state;
		logic [31:0] requested_address;
		logic        reached;
	} link_report_t;

	// One row of the directed plan: the transaction to send and, where the
	// answer is obvious, the report typed in by hand.
	typedef struct {
		link_item_t   item;
		bit           fixed;
		link_report_t report;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [1:0] cfg_idx;
	logic [7:0] cfg_wdata;

	ulfr_in_if  item_if ();
	ulfr_out_if result_if ();

	update_link_frame_receiver u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_if),
		.result    (result_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the receiver: configuration, frame assembly and link state.
	logic [7:0]  esc_code   = ESCAPE_RESET;
	logic [7:0]  start_code = START_RESET;
	logic [7:0]  mask_code  = MASK_RESET;
	logic [7:0]  rx_frame [STORE_DEPTH];
	int          rx_fill    = 0;
	bit          rx_esc     = 1'b0;
	logic [11:0] idle_count = '0;
	logic [11:0] idle_limit = '0;
	bit          wait_open  = 1'b0;
	logic [3:0]  hoped      = ST_IDLE;
	logic [3:0]  link_now   = ST_IDLE;
	logic [31:0] addr_now   = '0;

	// Reports still owed by the block, oldest first.
	link_report_t pending_reports [$];

	int          mismatches = 0;
	int          taken_items = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_ask = 0;

	plan_row_t plan [$];

	// 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops a report.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("update_link_frame_receiver_tb: done, errors");
		$finish;
	end

	// Advance the shadow model by one accepted transaction. consumed says
	// whether the block acts on it at all; produced says a report is owed.
	function automatic void track_link(input link_item_t it, output bit consumed,
			output bit produced, output link_report_t rep);
		logic [7:0] val;
		consumed = 1'b0;
		produced = 1'b0;
		rep = '0;
		if (it.kind == KIND_WAIT) begin
			// Opening a wait restarts everything, even mid-frame.
			idle_limit = it.wait_timeout;
			hoped = it.expected_state;
			if (it.force_state)
				link_now = it.new_state;
			rx_fill = 0;
			rx_esc = 1'b0;
			idle_count = '0;
			wait_open = 1'b1;
			consumed = 1'b1;
		end else if (wait_open && it.kind == KIND_TICK) begin
			consumed = 1'b1;
			if (idle_count >= idle_limit) begin
				wait_open = 1'b0;
				produced = 1'b1;
				rep = '{OUTCOME_TIMEOUT, link_now, addr_now, 1'b0};
			end else
				idle_count = idle_count + 12'd1;
		end else if (wait_open && it.kind == KIND_BYTE) begin
			consumed = 1'b1;
			idle_count = '0;
			if (it.rx_byte == esc_code)
				rx_esc = 1'b1;   // a second escape keeps the flag and stores nothing
			else begin
				val = rx_esc ? (it.rx_byte ^ mask_code) : it.rx_byte;
				rx_esc = 1'b0;
				// Before the start the byte lands in entry 0 but is not counted;
				// the start test looks at the raw byte.
				rx_frame[rx_fill] = val;
				if (rx_fill != 0 || it.rx_byte == start_code)
					rx_fill++;
				if (rx_fill == STORE_DEPTH) begin
					rx_fill = 0;
					wait_open = 1'b0;
					if (rx_frame[IDX_ID_A] == ID_WORD_A && rx_frame[IDX_ID_B] == ID_WORD_B) begin
						case (rx_frame[IDX_PRIM])
							PRIM_PWR_ACK: if (link_now == ST_PWR_REQ) link_now = ST_PWR_ACK;
							PRIM_VER_ACK: if (link_now == ST_VER_REQ) link_now = ST_VER_ACK;
							PRIM_ADDR_REQ: if (link_now == ST_XFER) begin
								addr_now = {rx_frame[IDX_ADDR3], rx_frame[IDX_ADDR2],
									rx_frame[IDX_ADDR1], rx_frame[IDX_ADDR0]};
								link_now = ST_DATA_REQ;
							end
							PRIM_END:     link_now = ST_COMPLETE;
							PRIM_CRC_ERR: link_now = ST_FAIL;
							default: ;
						endcase
					end
					produced = 1'b1;
					rep = '{OUTCOME_FRAME, link_now, addr_now, link_now == hoped};
				end
			end
		end
	endfunction

	function automatic link_item_t junk_item();
		junk_item = link_item_t'(31'($urandom));
	endfunction

	function automatic plan_row_t byte_row(input logic [7:0] b);
		byte_row = '{'{KIND_BYTE, b, 12'd0, 4'd0, 1'b0, 4'd0}, 1'b0, '0};
	endfunction

	function automatic plan_row_t tick_row();
		tick_row = '{'{KIND_TICK, 8'd0, 12'd0, 4'd0, 1'b0, 4'd0}, 1'b0, '0};
	endfunction

	function automatic plan_row_t wait_row(input logic [11:0] lim, input logic [3:0] hope,
			input logic frc, input logic [3:0] nst);
		wait_row = '{'{KIND_WAIT, 8'd0, lim, hope, frc, nst}, 1'b0, '0};
	endfunction

	function automatic plan_row_t expecting(input plan_row_t r, input link_report_t rep);
		expecting = r;
		expecting.fixed = 1'b1;
		expecting.report = rep;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic present(input link_item_t it);
		item_if.kind           <= it.kind;
		item_if.rx_byte        <= it.rx_byte;
		item_if.wait_timeout   <= it.wait_timeout;
		item_if.expected_state <= it.expected_state;
		item_if.force_state    <= it.force_state;
		item_if.new_state      <= it.new_state;
	endtask

	// Offer one transaction. Called at a falling edge, returns at the falling
	// edge after acceptance with valid still high, so back-to-back items never
	// drop valid in between.
	task automatic offer(input link_item_t it, input bit fixed = 1'b0,
			input link_report_t fixed_rep = '0);
		bit consumed;
		bit produced;
		link_report_t rep;
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			item_if.valid <= 1'b0;
			present(junk_item());
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		present(it);
		do
			@(posedge clk);
		while (item_if.ready !== 1'b1);
		track_link(it, consumed, produced, rep);
		if (consumed)
			taken_items++;
		if (fixed)
			pending_reports.push_back(fixed_rep);
		else if (produced)
			pending_reports.push_back(rep);
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		link_item_t it;
		it = junk_item();
		it.kind = KIND_BYTE;
		it.rx_byte = b;
		offer(it);
	endtask

	task automatic send_tick();
		link_item_t it;
		it = junk_item();
		it.kind = KIND_TICK;
		offer(it);
	endtask

	task automatic send_wait(input logic [11:0] lim, input logic [3:0] hope, input logic frc,
			input logic [3:0] nst);
		link_item_t it;
		it = junk_item();
		it.kind = KIND_WAIT;
		it.wait_timeout = lim;
		it.expected_state = hope;
		it.force_state = frc;
		it.new_state = nst;
		offer(it);
	endtask

	// Send one frame byte, stuffing it when it collides with the escape code
	// and now and then when it does not, unless the stuffed value is the escape code.
	task automatic send_data(input logic [7:0] val);
		if ((val == esc_code || $urandom_range(9, 0) == 0) && (val ^ mask_code) != esc_code) begin
			if ($urandom_range(7, 0) == 0)
				send_byte(esc_code);
			send_byte(esc_code);
			send_byte(val ^ mask_code);
		end else
			send_byte(val);
	endtask

	// One host session: mostly a well-formed frame aimed at the current link
	// state, otherwise a timeout, a frame cut short, or plain noise.
	task automatic run_session();
		int unsigned pick;
		int unsigned n;
		int unsigned lim;
		int unsigned gap_max;
		int unsigned upto;
		bit          frc;
		logic [3:0]  nst;
		logic [3:0]  from;
		logic [3:0]  hope;
		logic [7:0]  prim;
		logic [7:0]  body [PACKET_BYTES];
		pick = $urandom_range(99, 0);
		if (pick >= 92) begin
			repeat ($urandom_range(6, 1))
				offer(junk_item());
			return;
		end
		n = $urandom_range(9, 0);
		lim = (n < 4) ? $urandom_range(3, 0) : (n < 8) ? $urandom_range(20, 4) :
			$urandom_range(4095, 0);
		if (pick >= 70 && lim > 6)
			lim = $urandom_range(6, 0);   // keep timeout runs short
		frc = 1'($urandom_range(1, 0));
		if ($urandom_range(9, 0) < 7) begin
			case ($urandom_range(2, 0))
				0: nst = ST_PWR_REQ;
				1: nst = ST_VER_REQ;
				default: nst = ST_XFER;
			endcase
		end else
			nst = 4'($urandom);
		from = frc ? nst : link_now;

		// Pick the primitive that moves the link on from where it stands.
		n = $urandom_range(9, 0);
		if (n < 6) begin
			case (from)
				ST_PWR_REQ: prim = PRIM_PWR_ACK;
				ST_VER_REQ: prim = PRIM_VER_ACK;
				ST_XFER:    prim = PRIM_ADDR_REQ;
				default:    prim = $urandom_range(1, 0) ? PRIM_END : PRIM_CRC_ERR;
			endcase
		end else if (n < 9)
			prim = PRIM_PWR_ACK + 8'($urandom_range(4, 0));
		else
			prim = 8'($urandom);
		case (prim)
			PRIM_PWR_ACK:  hope = ST_PWR_ACK;
			PRIM_VER_ACK:  hope = ST_VER_ACK;
			PRIM_ADDR_REQ: hope = ST_DATA_REQ;
			PRIM_END:      hope = ST_COMPLETE;
			PRIM_CRC_ERR:  hope = ST_FAIL;
			default:       hope = from;
		endcase
		if ($urandom_range(3, 0) == 0)
			hope = 4'($urandom);

		foreach (body[i])
			body[i] = 8'($urandom);
		body[IDX_ID_A - 1] = ID_WORD_A;
		body[IDX_ID_B - 1] = ID_WORD_B;
		body[IDX_PRIM - 1] = prim;
		if ($urandom_range(11, 0) == 0)
			body[$urandom_range(IDX_ID_B - 1, IDX_ID_A - 1)] = 8'($urandom);

		send_wait(12'(lim), hope, frc, nst);
		repeat ($urandom_range(2, 0))
			send_byte(8'($urandom));   // line noise ahead of the start
		if ($urandom_range(9, 0) == 0)
			send_byte(esc_code);       // the start test sees the raw byte
		send_byte(start_code);

		if (pick < 70) begin
			gap_max = (lim < 3) ? lim : 3;
			foreach (body[i]) begin
				if (gap_max != 0 && $urandom_range(4, 0) == 0)
					repeat ($urandom_range(gap_max, 1))
						send_tick();
				send_data(body[i]);
			end
		end else if (pick < 85) begin
			upto = $urandom_range(4, 0);
			for (int i = 0; i < upto; i++)
				send_data(body[i]);
			repeat (lim + 1)
				send_tick();
			if ($urandom_range(1, 0) == 0)
				send_byte(8'($urandom));   // nothing listening, must be dropped
		end else begin
			// Leave the frame unfinished; the next wait restarts assembly.
			upto = $urandom_range(PACKET_BYTES - 1, 0);
			for (int i = 0; i < upto; i++)
				send_data(body[i]);
		end
	endtask

	// Drop valid, wait until every owed report is in, then let the pipe empty.
	task automatic settle(input int cycles);
		item_if.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (cycles)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic set_link_config(input logic [7:0] esc, input logic [7:0] start,
			input logic [7:0] mask);
		settle(CFG_SETTLE);
		write_reg(CFG_ESCAPE_BYTE, esc);
		write_reg(CFG_START_BYTE, start);
		write_reg(CFG_STUFF_MASK, mask);
		cfg_wr_en <= 1'b0;
		esc_code = esc;
		start_code = start;
		mask_code = mask;
	endtask

	// Receiver pacing: random stalls, plus a long hold-off on request so the
	// result register fills and the block has to stall its input.
	initial begin : result_pacing
		int unsigned hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask != 0) begin
				hold_left = hold_ask;
				hold_ask = 0;
			end
			if (hold_left != 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else
				result_if.ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Compare every accepted result transaction with the oldest owed report.
	always @(posedge clk) begin : result_check
		link_report_t want;
		if (arst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("result transaction with no report owed");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("outcome", 32'(want.outcome), 32'(result_if.outcome));
				check_field("link_state", 32'(want.link_state), 32'(result_if.link_state));
				check_field("requested_address", want.requested_address,
					result_if.requested_address);
				check_field("reached", 32'(want.reached), 32'(result_if.reached));
			end
		end
	end

	initial begin : stimulus
		// Hold every input at a known value through reset.
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_idx = CFG_ESCAPE_BYTE;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.kind = KIND_BYTE;
		item_if.rx_byte = '0;
		item_if.wait_timeout = '0;
		item_if.expected_state = '0;
		item_if.force_state = 1'b0;
		item_if.new_state = '0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed plan, run with the reset configuration (escape 7D, start 7E,
		// stuff mask 20).
		plan = '{
			byte_row(8'h7E),                                      // no wait open: drop
			'{'{KIND_SPARE, 8'hFF, 12'hFFF, 4'hF, 1'b1, 4'hF}, 1'b0, '0},
			wait_row(12'd0, ST_IDLE, 1'b0, ST_IDLE),
			expecting(tick_row(), '{OUTCOME_TIMEOUT, ST_IDLE, 32'd0, 1'b0}),
			wait_row(12'hFFF, ST_PWR_ACK, 1'b1, ST_PWR_REQ),
			byte_row(8'h00),                                      // before the start
			byte_row(8'h7E),
			byte_row(ID_WORD_A),
			byte_row(ID_WORD_B),
			byte_row(PRIM_PWR_ACK),
			byte_row(8'h00),
			byte_row(8'h00),
			byte_row(8'h00),
			byte_row(8'h00),
			expecting(byte_row(8'hFF), '{OUTCOME_FRAME, ST_PWR_ACK, 32'd0, 1'b1}),
			wait_row(12'd1, ST_DATA_REQ, 1'b1, ST_XFER),
			byte_row(8'h7E),
			byte_row(8'h7D),
			byte_row(8'h7D),                                      // escape while pending
			byte_row(8'h7E),                                      // destuffs to the first id
			tick_row(),
			byte_row(ID_WORD_B),
			byte_row(PRIM_ADDR_REQ),
			byte_row(8'hFF),
			byte_row(8'h7E),                                      // start inside a frame is data
			byte_row(8'h00),
			byte_row(8'h80),
			byte_row(8'h00)
		};
		sender_idle_pct = 29;
		stall_pct = 78;
		foreach (plan[i])
			offer(plan[i].item, plan[i].fixed, plan[i].report);

		// Random segments. Each segment runs with one register setting, the reset one in segments 0
		// and 4; the pacing moves from receiver-heavy to sender-heavy gaps, then none.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: ;
				1: set_link_config(8'h00, 8'hFF, 8'h00);
				2: set_link_config(8'hFF, 8'h00, 8'hFF);
				4: set_link_config(ESCAPE_RESET, START_RESET, MASK_RESET);
				default: set_link_config(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			sender_idle_pct = (seg < 2) ? 29 : (seg < 4) ? 78 : 0;
			stall_pct = (seg < 2) ? 78 : (seg < 4) ? 29 : 0;
			if (seg == 1 || seg == 4)
				hold_ask = HOLD_CYCLES;
			taken_items = 0;
			while (taken_items < SEG_ITEMS)
				run_session();
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0)
			$display("update_link_frame_receiver_tb: done, clean");
		else
			$display("update_link_frame_receiver_tb: done, errors");
		$finish;
	end

endmodule
